>>> hw/rtl/lpht_pkg.sv
// Shared types and fixed field widths for the linear probing hash table.
// No dependencies; compile first.
package lpht_pkg;

	localparam int KEY_W    = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 10;
	localparam int PROBE_W  = 10;
	localparam int OCC_W    = 11;

	// home-slot reduction takes this many key bits per cycle
	localparam int MOD_DIG   = 4;
	localparam int MOD_STEPS = KEY_W / MOD_DIG;

	typedef enum logic [KIND_W-1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		TAG_FREE = 2'd0,
		TAG_USED = 2'd1,
		TAG_GONE = 2'd2
	} tag_t;

	typedef struct packed {
		tag_t             tag;
		logic [KEY_W-1:0] key;
	} entry_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_DONE
	} state_t;

endpackage

>>> hw/rtl/lpht_if.sv
// Request and response channel interfaces of the hash table.
// Depends on lpht_pkg for field widths.
interface lpht_req_if;
	import lpht_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	modport source (output valid, output kind, output key, input ready);
	modport sink   (input valid, input kind, input key, output ready);
endinterface

interface lpht_rsp_if;
	import lpht_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [PROBE_W-1:0]  probe_count;
	logic [OCC_W-1:0]    occupied_count;
	modport source (output valid, output status, output slot, output probe_count,
		output occupied_count, input ready);
	modport sink   (input valid, input status, input slot, input probe_count,
		input occupied_count, output ready);
endinterface

>>> hw/rtl/lpht_mod_unit.sv
// Home slot unit: key mod TABLE_SIZE, MOD_DIG key bits per cycle, or the low key bits for a power of two.
// Depends on lpht_pkg.
module lpht_mod_unit #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lpht_pkg::KEY_W-1:0]    key,
	output logic                          done,
	output logic [$clog2(TABLE_SIZE)-1:0] home
);
	import lpht_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int REM_W  = IDX_W + 1;
	localparam int STEP_W = $clog2(MOD_STEPS);
	localparam logic [REM_W-1:0] MODULUS = REM_W'(TABLE_SIZE);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MOD_STEPS - 1);
	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_d;

	// shift in MOD_DIG key bits one at a time, subtracting the modulus once after each if reached
	always_comb begin
		rem_d = {1'b0, rem_q};
		for (int i = 0; i < MOD_DIG; i++) begin
			rem_d = {rem_d[REM_W-2:0], key_q[KEY_W-1-i]};
			if (rem_d >= MODULUS) begin
				rem_d = rem_d - MODULUS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (IS_POW2) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					step_q <= '0;
				end
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			rem_q <= IS_POW2 ? key[IDX_W-1:0] : '0;
		end else if (busy_q) begin
			key_q <= key_q << MOD_DIG;
			rem_q <= rem_d[IDX_W-1:0];
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule

>>> hw/rtl/linear_probe_hash_table_top.sv
// Top level of the open-addressed hash table with linear probing.
// Depends on lpht_pkg, lpht_if and lpht_mod_unit.
//
//   channel | modport | transfer when          | payload
//   --------+---------+------------------------+-------------------------------------------
//   req     | sink    | req.valid & req.ready  | kind, key
//   rsp     | source  | rsp.valid & rsp.ready  | status, slot, probe_count, occupied_count
//
// Steps: the transfer, then the home slot (taken from the low key bits when TABLE_SIZE is a
// power of two, from the 4-bit-per-cycle mod unit otherwise), then one probed slot per
// cycle through the single-port table memory, then the move into the output register.
// Clear walks the memory one slot a cycle.
// Reset: a clearing pass frees every slot; req.ready stays low meanwhile.
// Stalls: a new request is taken while a result waits in the output register; a
// finished result waits in its own state until the output register frees up.
module linear_probe_hash_table_top #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic clk,
	input  logic arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	// table: tag and key of every slot, one read or write a cycle
	entry_t mem [TABLE_SIZE];
	entry_t rd_q;
	logic             mem_we;
	logic             mem_re;
	logic [IDX_W-1:0] mem_addr;
	entry_t           mem_wdata;

	state_t state_q, state_d;

	logic [IDX_W-1:0] sweep_q;
	logic [CNT_W-1:0] cnt_q;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] s_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] s_next;

	// finished result waiting for the output register
	status_t          res_status_q;
	logic [IDX_W-1:0] res_slot_q;
	logic [IDX_W-1:0] res_probe_q;

	// output register
	logic                out_valid_q;
	status_t             out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [PROBE_W-1:0]  out_probe_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic             mod_start;
	logic             mod_done;
	logic [IDX_W-1:0] home;

	logic             accept;
	logic             sweep_adv;
	logic             adv;
	logic             fin;
	status_t          fin_status;
	logic [IDX_W-1:0] fin_slot;
	logic [IDX_W-1:0] fin_probe;
	logic             cnt_inc;
	logic             cnt_dec;
	logic             cnt_clr;
	logic             load_out;
	logic             key_hit;
	logic             last_probe;

	lpht_mod_unit #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_mod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.key   (req.key),
		.done  (mod_done),
		.home  (home)
	);

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign s_next     = (s_q == LAST_IDX) ? '0 : s_q + IDX_W'(1);
	assign key_hit    = (rd_q.tag == TAG_USED) && (rd_q.key == key_q);
	assign last_probe = (n_q == LAST_IDX);

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_addr   = s_q;
		mem_wdata  = '{tag: TAG_FREE, key: key_q};
		mod_start  = 1'b0;
		sweep_adv  = 1'b0;
		adv        = 1'b0;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_slot   = '0;
		fin_probe  = n_q;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		cnt_clr    = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			S_INIT, S_CLEAR: begin
				// free one slot a cycle
				mem_we    = 1'b1;
				mem_addr  = sweep_q;
				sweep_adv = 1'b1;
				cnt_clr   = 1'b1;
				if (sweep_q == LAST_IDX) begin
					if (state_q == S_CLEAR) begin
						fin       = 1'b1;
						fin_probe = '0;
						state_d   = S_DONE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (op_t'(req.kind) == OP_CLEAR) begin
						state_d = S_CLEAR;
					end else begin
						mod_start = 1'b1;
						state_d   = S_HASH;
					end
				end
			end
			S_HASH: begin
				// fetch the home slot as soon as it is known
				if (mod_done) begin
					mem_re   = 1'b1;
					mem_addr = home;
					state_d  = S_PROBE;
				end
			end
			S_PROBE: begin
				// rd_q holds slot s_q; decide, or fetch the next slot
				if (op_q == OP_INSERT) begin
					if (rd_q.tag != TAG_USED) begin
						mem_we    = 1'b1;
						mem_wdata = '{tag: TAG_USED, key: key_q};
						cnt_inc   = 1'b1;
						fin       = 1'b1;
						fin_slot  = s_q;
					end else if (last_probe) begin
						fin        = 1'b1;
						fin_status = ST_FULL;
					end else begin
						adv = 1'b1;
					end
				end else begin
					if (rd_q.tag == TAG_FREE) begin
						fin        = 1'b1;
						fin_status = ST_MISS;
					end else if (key_hit) begin
						fin      = 1'b1;
						fin_slot = s_q;
						if (op_q == OP_DELETE) begin
							mem_we    = 1'b1;
							mem_wdata = '{tag: TAG_GONE, key: key_q};
							cnt_dec   = (cnt_q != '0);
						end
					end else if (last_probe) begin
						fin        = 1'b1;
						fin_status = ST_MISS;
					end else begin
						adv = 1'b1;
					end
				end
				if (adv) begin
					mem_re   = 1'b1;
					mem_addr = s_next;
				end
				if (fin) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register is empty or being emptied
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sweep_q <= '0;
			end else if (sweep_adv) begin
				sweep_q <= sweep_q + IDX_W'(1);
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(req.kind);
			key_q <= req.key;
		end
		if (state_q == S_HASH && mod_done) begin
			s_q <= home;
			n_q <= '0;
		end else if (adv) begin
			s_q <= s_next;
			n_q <= n_q + IDX_W'(1);
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_slot_q   <= fin_slot;
			res_probe_q  <= fin_probe;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_slot_q   <= SLOT_W'(res_slot_q);
			out_probe_q  <= PROBE_W'(res_probe_q);
			out_occ_q    <= OCC_W'(cnt_q);
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.slot           = out_slot_q;
	assign rsp.probe_count    = out_probe_q;
	assign rsp.occupied_count = out_occ_q;

endmodule
